FILE: hdl/ptp_best_master_select_defines.svh
// Assertion macros shared by the checker of the best master selection block
`ifndef PTP_BEST_MASTER_SELECT_DEFINES_SVH
`define PTP_BEST_MASTER_SELECT_DEFINES_SVH

// Concurrent check on the rising clock edge, masked while reset is high
`define PTPBMS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Concurrent check on the rising clock edge that also holds through reset
`define PTPBMS_ASSERT_NR(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: hdl/ptpbms_pkg.sv
// Types, constants and register indexes of the best master selection block
package ptpbms_pkg;

   localparam int REQ_DATA_W = 280;
   localparam int RSP_DATA_W = 248;
   localparam int RSP_PAD_W  = 7;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_ADDR_W-1:0] CSR_SLAVE_MODE = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_THRESHOLD  = 1'd1;

   localparam logic       SLAVE_MODE_RST = 1'b1;
   localparam logic [7:0] THRESHOLD_RST  = 8'd10;

   localparam logic [15:0] STEPS_MAX = 16'hFFFF;

   // Bit positions in the second flag octet of an announce
   localparam int FLAG_LEAP61     = 0;
   localparam int FLAG_LEAP59     = 1;
   localparam int FLAG_UTC_VALID  = 2;
   localparam int FLAG_PTP_SCALE  = 3;
   localparam int FLAG_TIME_TRACE = 4;
   localparam int FLAG_FREQ_TRACE = 5;

   // Announce as carried on req_tdata, first member in the highest bits
   typedef struct packed {
      logic [47:0]        master_address;
      logic signed [15:0] utc_offset;
      logic [7:0]         flag_octet;
      logic [15:0]        sender_port;
      logic [63:0]        sender_identity;
      logic [15:0]        hops_removed;
      logic [7:0]         gm_priority2;
      logic [15:0]        gm_log_variance;
      logic [7:0]         gm_clock_accuracy;
      logic [7:0]         gm_clock_class;
      logic [7:0]         gm_priority1;
      logic [63:0]        gm_identity;
   } announce_type;

   // Stored best record used for ranking
   typedef struct packed {
      logic [63:0] gm_identity;
      logic [7:0]  priority1;
      logic [7:0]  clock_class;
      logic [7:0]  accuracy;
      logic [15:0] variance;
      logic [7:0]  priority2;
      logic [15:0] hops;
      logic [63:0] sender_identity;
      logic [15:0] sender_port;
   } best_type;

   typedef struct packed {
      logic       slave_mode;
      logic [7:0] switch_threshold;
   } cfg_type;

   // Result as carried on rsp_tdata, first member in the highest bits
   typedef struct packed {
      logic [RSP_PAD_W-1:0] pad;
      logic                 no_master_yet;
      logic [4:0]           time_flags;
      logic                 utc_valid;
      logic signed [15:0]   utc_offset_out;
      logic [63:0]          grandmaster_id_out;
      logic [15:0]          parent_port;
      logic [63:0]          parent_identity;
      logic [15:0]          steps_out;
      logic [47:0]          best_address;
      logic [7:0]           pending_count;
      logic                 candidate_better;
      logic                 adopted;
   } result_type;

endpackage

FILE: hdl/ptp_best_master_select.sv
// Best master selection: PTP announces in, selection result per announce out
//
// req_ channel: one received announce per transfer, fields packed in req_tdata.
// rsp_ channel: exactly one result per announce, in order, packed in rsp_tdata.
// csr_ port: write slave_mode (index 0) and switch_threshold (index 1) while idle.
// An accepted announce sits in the input register, is ranked against the
// stored best record, and the edge that moves it on updates the record and
// loads the result register together; rsp_tvalid comes from that register.
// Throughput is one announce per cycle while the rsp_ side takes results;
// the record update is a single pass of comparison logic, so each announce
// sees the record left by the one before. A stalled rsp_ side holds its
// result; the input register still takes one more announce, then req_tready
// drops until the result is taken. Reset clears the record (no master yet),
// the switch counter and the valid flags of both channel registers, and
// restores slave_mode to 1 and switch_threshold to 10.
module ptp_best_master_select
   import ptpbms_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // gm_identity, gm_priority1, gm_clock_class, gm_clock_accuracy,
   // gm_log_variance, gm_priority2, hops_removed, sender_identity,
   // sender_port, flag_octet, utc_offset, master_address
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // adopted, candidate_better, pending_count, best_address, steps_out,
   // parent_identity, parent_port, grandmaster_id_out, utc_offset_out,
   // utc_valid, time_flags, no_master_yet, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type      cfg_ff;
   logic         s1_valid_ff, s1_valid_in;
   announce_type s1_data_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   result_type   rsp_data_ff;
   result_type   result;
   logic         advance;
   logic         req_fire;

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slave_mode       <= SLAVE_MODE_RST;
         cfg_ff.switch_threshold <= THRESHOLD_RST;
      end else if (csr_we) begin
         if (csr_addr == CSR_SLAVE_MODE) begin
            cfg_ff.slave_mode <= csr_wdata[0];
         end else if (csr_addr == CSR_THRESHOLD) begin
            cfg_ff.switch_threshold <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_data_ff <= announce_type'(req_tdata);
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   ptpbms_dataset u_dataset (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .cand   (s1_data_ff),
      .cfg    (cfg_ff),
      .result (result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_data_ff);

endmodule

FILE: hdl/ptpbms_rank.sv
// Dataset comparison of a received announce against the stored best record
module ptpbms_rank
   import ptpbms_pkg::*;
(
   input  announce_type cand,
   input  best_type     best,
   output logic         cand_better
);

   logic [111:0] cand_key;
   logic [111:0] best_key;
   logic [16:0]  hops_a;
   logic [16:0]  hops_b;
   logic         same_gm;
   logic         sid_less;
   logic         sid_equal;

   assign cand_key = {cand.gm_priority1, cand.gm_clock_class, cand.gm_clock_accuracy,
                      cand.gm_log_variance, cand.gm_priority2, cand.gm_identity};
   assign best_key = {best.priority1, best.clock_class, best.accuracy,
                      best.variance, best.priority2, best.gm_identity};

   assign hops_a    = {1'b0, cand.hops_removed};
   assign hops_b    = {1'b0, best.hops};
   assign same_gm   = (cand.gm_identity == best.gm_identity);
   assign sid_less  = (cand.sender_identity < best.sender_identity);
   assign sid_equal = (cand.sender_identity == best.sender_identity);

   always_comb begin
      priority if (!same_gm) begin
         cand_better = (cand_key < best_key);
      end else if (hops_a > hops_b + 17'd1) begin
         cand_better = 1'b0;
      end else if (hops_a + 17'd1 < hops_b) begin
         cand_better = 1'b1;
      end else if (hops_a > hops_b) begin
         // one step further away: ranked on sender against the parent
         cand_better = sid_less;
      end else if (hops_a < hops_b) begin
         // one step closer: parent compared with itself, never better
         cand_better = 1'b0;
      end else begin
         cand_better = sid_less || (sid_equal && (cand.sender_port < best.sender_port));
      end
   end

endmodule

FILE: hdl/ptpbms_dataset.sv
// Best master record, switch counter and held parent and time properties
module ptpbms_dataset
   import ptpbms_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  announce_type cand,
   input  cfg_type      cfg,
   output result_type   result
);

   logic        empty_ff, empty_in;
   best_type    best_ff, best_in;
   logic [7:0]  count_ff, count_in;
   logic [47:0] addr_ff, addr_in;
   logic [15:0] steps_ff, steps_in;
   logic [15:0] utc_ff, utc_in;
   logic        utc_valid_ff, utc_valid_in;
   logic [4:0]  tflags_ff, tflags_in;

   logic        rank_better;
   logic        better;
   logic        adopt;
   logic [7:0]  count_inc;
   logic [7:0]  fl;

   ptpbms_rank u_rank (
      .cand        (cand),
      .best        (best_ff),
      .cand_better (rank_better)
   );

   assign fl        = cand.flag_octet;
   assign better    = !empty_ff && rank_better;
   assign count_inc = count_ff + 8'd1;
   assign adopt     = empty_ff || (better && (count_inc >= cfg.switch_threshold));

   always_comb begin
      empty_in     = empty_ff;
      best_in      = best_ff;
      addr_in      = addr_ff;
      steps_in     = steps_ff;
      utc_in       = utc_ff;
      utc_valid_in = utc_valid_ff;
      tflags_in    = tflags_ff;
      count_in     = better ? count_inc : 8'd0;
      if (adopt) begin
         empty_in                = 1'b0;
         count_in                = 8'd0;
         best_in.gm_identity     = cand.gm_identity;
         best_in.priority1       = cand.gm_priority1;
         best_in.clock_class     = cand.gm_clock_class;
         best_in.accuracy        = cand.gm_clock_accuracy;
         best_in.variance        = cand.gm_log_variance;
         best_in.priority2       = cand.gm_priority2;
         best_in.hops            = cand.hops_removed;
         best_in.sender_identity = cand.sender_identity;
         best_in.sender_port     = cand.sender_port;
         addr_in                 = cand.master_address;
         steps_in = (cand.hops_removed == STEPS_MAX) ? STEPS_MAX
                                                     : cand.hops_removed + 16'd1;
         utc_in       = cand.utc_offset;
         utc_valid_in = fl[FLAG_UTC_VALID];
         // leap, timescale and traceability flags follow the master only in slave mode
         if (cfg.slave_mode) begin
            tflags_in = {fl[FLAG_PTP_SCALE], fl[FLAG_FREQ_TRACE], fl[FLAG_TIME_TRACE],
                         fl[FLAG_LEAP61], fl[FLAG_LEAP59]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         empty_ff     <= 1'b1;
         best_ff      <= '0;
         count_ff     <= '0;
         addr_ff      <= '0;
         steps_ff     <= '0;
         utc_ff       <= '0;
         utc_valid_ff <= 1'b0;
         tflags_ff    <= '0;
      end else if (step) begin
         empty_ff     <= empty_in;
         best_ff      <= best_in;
         count_ff     <= count_in;
         addr_ff      <= addr_in;
         steps_ff     <= steps_in;
         utc_ff       <= utc_in;
         utc_valid_ff <= utc_valid_in;
         tflags_ff    <= tflags_in;
      end
   end

   always_comb begin
      result                    = '0;
      result.adopted            = adopt;
      result.candidate_better   = better;
      result.pending_count      = count_in;
      result.best_address       = addr_in;
      result.steps_out          = steps_in;
      result.parent_identity    = best_in.sender_identity;
      result.parent_port        = best_in.sender_port;
      result.grandmaster_id_out = best_in.gm_identity;
      result.utc_offset_out     = utc_in;
      result.utc_valid          = utc_valid_in;
      result.time_flags         = tflags_in;
      result.no_master_yet      = empty_in;
   end

endmodule

FILE: hdl/ptpbms_checker.sv
// Port-level checks of the best master selection block and their binding
`include "ptp_best_master_select_defines.svh"

module ptpbms_checker
   import ptpbms_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready
);

   result_type rsp;
   logic       stalled;
   logic       win_held;
   logic       count_zero;

   assign rsp        = result_type'(rsp_tdata);
   assign stalled    = rsp_tvalid && !rsp_tready;
   assign win_held   = rsp.candidate_better && !rsp.adopted;
   assign count_zero = (rsp.pending_count == 8'd0);

   // hold a stalled result
   `PTPBMS_ASSERT(a_rsp_hold, stalled |=> rsp_tvalid && $stable(rsp_tdata), "stalled result changed")
   // every result follows an announce, so a master is always known by then
   `PTPBMS_ASSERT(a_master_known, rsp_tvalid |-> !rsp.no_master_yet, "result reports no master")
   // adoption and a lost comparison both clear the switch counter
   `PTPBMS_ASSERT(a_count_clear, rsp_tvalid && !win_held |-> count_zero, "counter not cleared")
   // a winning announce that was not adopted has a count of at least one
   `PTPBMS_ASSERT(a_count_run, rsp_tvalid && win_held |-> !count_zero, "win not counted")
   `PTPBMS_ASSERT_NR(a_reset_idle, reset |=> !rsp_tvalid, "result valid after reset")

endmodule

bind ptp_best_master_select ptpbms_checker u_ptpbms_checker (.*);

FILE: bench/tb_top.sv
// Self-checking bench for the PTP best master selection block: directed and random announces
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import ptpbms_pkg::*;

   localparam int STALL_LIMIT     = 1000;
   localparam int HOLD_OFF_CYCLES = 48;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   // gm_identity, gm_priority1, gm_clock_class, gm_clock_accuracy, gm_log_variance,
   // gm_priority2, hops_removed, sender_identity, sender_port, flag_octet,
   // utc_offset, master_address
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // adopted, candidate_better, pending_count, best_address, steps_out,
   // parent_identity, parent_port, grandmaster_id_out, utc_offset_out,
   // utc_valid, time_flags, no_master_yet, zero fill
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = CSR_SLAVE_MODE;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int req_idle_pct = 22;
   int rsp_idle_pct = 22;
   bit hold_off_req = 1'b0;

   // Tracks the selected master and the results each announce must produce
   class selection_scoreboard;
      best_type         best;
      bit               have_best;
      logic [7:0]       win_count;
      logic [47:0]      held_address;
      logic [15:0]      held_steps;
      logic signed [15:0] held_utc;
      logic             held_utc_valid;
      logic [4:0]       held_flags;
      logic             slave;
      logic [7:0]       threshold;
      result_type       awaited_results[$];
      int               errors;

      function new();
         best           = '0;
         have_best      = 1'b0;
         win_count      = '0;
         held_address   = '0;
         held_steps     = '0;
         held_utc       = '0;
         held_utc_valid = 1'b0;
         held_flags     = '0;
         slave          = SLAVE_MODE_RST;
         threshold      = THRESHOLD_RST;
         errors         = 0;
      endfunction

      function void set_register(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         if (idx == CSR_SLAVE_MODE) begin
            slave = val[0];
         end else if (idx == CSR_THRESHOLD) begin
            threshold = val;
         end
      endfunction

      function int compare_unsigned(logic [63:0] x, logic [63:0] y);
         return (x < y) ? -1 : ((x > y) ? 1 : 0);
      endfunction

      // Negative when the candidate outranks the stored best
      function int rank_against_best(announce_type a);
         logic [16:0] ha, hb;
         if (a.gm_identity != best.gm_identity) begin
            if (a.gm_priority1 != best.priority1)
               return compare_unsigned(64'(a.gm_priority1), 64'(best.priority1));
            if (a.gm_clock_class != best.clock_class)
               return compare_unsigned(64'(a.gm_clock_class), 64'(best.clock_class));
            if (a.gm_clock_accuracy != best.accuracy)
               return compare_unsigned(64'(a.gm_clock_accuracy), 64'(best.accuracy));
            if (a.gm_log_variance != best.variance)
               return compare_unsigned(64'(a.gm_log_variance), 64'(best.variance));
            if (a.gm_priority2 != best.priority2)
               return compare_unsigned(64'(a.gm_priority2), 64'(best.priority2));
            return compare_unsigned(a.gm_identity, best.gm_identity);
         end
         ha = {1'b0, a.hops_removed};
         hb = {1'b0, best.hops};
         if (ha > hb + 1) return 1;
         if (ha + 1 < hb) return -1;
         // one step further away: candidate sender against the parent
         if (ha > hb) return compare_unsigned(a.sender_identity, best.sender_identity);
         // one step closer: parent against itself, always a tie
         if (ha < hb) return 0;
         if (a.sender_identity != best.sender_identity)
            return compare_unsigned(a.sender_identity, best.sender_identity);
         return compare_unsigned(64'(a.sender_port), 64'(best.sender_port));
      endfunction

      function void take_as_best(announce_type a);
         logic [7:0] f;
         f                    = a.flag_octet;
         best.gm_identity     = a.gm_identity;
         best.priority1       = a.gm_priority1;
         best.clock_class     = a.gm_clock_class;
         best.accuracy        = a.gm_clock_accuracy;
         best.variance        = a.gm_log_variance;
         best.priority2       = a.gm_priority2;
         best.hops            = a.hops_removed;
         best.sender_identity = a.sender_identity;
         best.sender_port     = a.sender_port;
         held_address         = a.master_address;
         held_steps = (a.hops_removed == STEPS_MAX) ? STEPS_MAX : a.hops_removed + 16'd1;
         held_utc             = a.utc_offset;
         held_utc_valid       = f[FLAG_UTC_VALID];
         if (slave) begin
            held_flags = {f[FLAG_PTP_SCALE], f[FLAG_FREQ_TRACE], f[FLAG_TIME_TRACE],
                          f[FLAG_LEAP61], f[FLAG_LEAP59]};
         end
      endfunction

      function void note_announce(announce_type a);
         result_type r;
         bit won;
         r   = '0;
         won = 1'b0;
         if (!have_best) begin
            take_as_best(a);
            have_best = 1'b1;
            win_count = '0;
            r.adopted = 1'b1;
         end else if (rank_against_best(a) < 0) begin
            won = 1'b1;
            win_count = win_count + 8'd1;
            if (win_count >= threshold) begin
               take_as_best(a);
               win_count = '0;
               r.adopted = 1'b1;
            end
         end else begin
            win_count = '0;
         end
         r.candidate_better   = won;
         r.pending_count      = win_count;
         r.best_address       = held_address;
         r.steps_out          = held_steps;
         r.parent_identity    = best.sender_identity;
         r.parent_port        = best.sender_port;
         r.grandmaster_id_out = best.gm_identity;
         r.utc_offset_out     = held_utc;
         r.utc_valid          = held_utc_valid;
         r.time_flags         = held_flags;
         r.no_master_yet      = !have_best;
         awaited_results.push_back(r);
      endfunction

      function void check_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (awaited_results.size() == 0) begin
            $error("result transfer with no announce outstanding");
            errors++;
            return;
         end
         want = awaited_results.pop_front();
         check_field("adopted", 64'(want.adopted), 64'(got.adopted));
         check_field("candidate_better", 64'(want.candidate_better),
                     64'(got.candidate_better));
         check_field("pending_count", 64'(want.pending_count), 64'(got.pending_count));
         check_field("best_address", 64'(want.best_address), 64'(got.best_address));
         check_field("steps_out", 64'(want.steps_out), 64'(got.steps_out));
         check_field("parent_identity", want.parent_identity, got.parent_identity);
         check_field("parent_port", 64'(want.parent_port), 64'(got.parent_port));
         check_field("grandmaster_id_out", want.grandmaster_id_out, got.grandmaster_id_out);
         check_field("utc_offset_out", 64'(want.utc_offset_out), 64'(got.utc_offset_out));
         check_field("utc_valid", 64'(want.utc_valid), 64'(got.utc_valid));
         check_field("time_flags", 64'(want.time_flags), 64'(got.time_flags));
         check_field("no_master_yet", 64'(want.no_master_yet), 64'(got.no_master_yet));
      endfunction
   endclass

   selection_scoreboard sb;

   ptp_best_master_select dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   // Result side back-pressure, with one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   initial begin
      int stall_cycles;
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("FAIL ptp_best_master_select");
      $finish;
   end

   function automatic announce_type random_announce();
      logic [287:0] raw;
      for (int i = 0; i < 9; i++) raw[i*32 +: 32] = $urandom;
      return raw[REQ_DATA_W-1:0];
   endfunction

   // New flags, UTC offset and address; the ranking fields stay
   function automatic announce_type refresh_payload(announce_type a);
      a.flag_octet     = 8'($urandom);
      a.utc_offset     = 16'($urandom);
      a.master_address = 48'({$urandom, $urandom});
      return a;
   endfunction

   function automatic announce_type announce_from(logic [63:0] gm, logic [7:0] p1,
         logic [7:0] cls, logic [7:0] acc, logic [15:0] variance, logic [7:0] p2,
         logic [15:0] hops, logic [63:0] sender, logic [15:0] port);
      announce_type a;
      a = refresh_payload('0);
      a.gm_identity       = gm;
      a.gm_priority1      = p1;
      a.gm_clock_class    = cls;
      a.gm_clock_accuracy = acc;
      a.gm_log_variance   = variance;
      a.gm_priority2      = p2;
      a.hops_removed      = hops;
      a.sender_identity   = sender;
      a.sender_port       = port;
      return a;
   endfunction

   function automatic logic [63:0] nudge(logic [63:0] v);
      case ($urandom_range(0, 4))
         0: return v + 64'd1;
         1: return v - 64'd1;
         2: return v + 64'd2;
         3: return v - 64'd2;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Announce close to the current best, differing from the chosen ranking step on
   function automatic announce_type derive_announce();
      announce_type a;
      best_type b;
      int level;
      a = random_announce();
      b = sb.best;
      level = $urandom_range(0, 7);
      if (level <= 5) begin
         if (level > 0) a.gm_priority1 = b.priority1;
         else a.gm_priority1 = 8'(nudge(64'(b.priority1)));
         if (level > 1) a.gm_clock_class = b.clock_class;
         else if (level == 1) a.gm_clock_class = 8'(nudge(64'(b.clock_class)));
         if (level > 2) a.gm_clock_accuracy = b.accuracy;
         else if (level == 2) a.gm_clock_accuracy = 8'(nudge(64'(b.accuracy)));
         if (level > 3) a.gm_log_variance = b.variance;
         else if (level == 3) a.gm_log_variance = 16'(nudge(64'(b.variance)));
         if (level > 4) a.gm_priority2 = b.priority2;
         else if (level == 4) a.gm_priority2 = 8'(nudge(64'(b.priority2)));
         if (level == 5) a.gm_identity = nudge(b.gm_identity);
      end else begin
         a.gm_identity = b.gm_identity;
         a.sender_identity = $urandom_range(0, 1) ? b.sender_identity : nudge(b.sender_identity);
         if (level == 6) begin
            a.hops_removed = 16'(b.hops + $urandom_range(0, 6) - 3);
         end else begin
            a.hops_removed = b.hops;
            a.sender_port  = 16'(nudge(64'(b.sender_port)));
         end
      end
      return a;
   endfunction

   function automatic announce_type find_challenger();
      announce_type a;
      a = derive_announce();
      for (int i = 0; i < 40 && sb.rank_against_best(a) >= 0; i++) a = derive_announce();
      return a;
   endfunction

   task automatic send_announce(input announce_type a);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata  <= a;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_announce(a);
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (sb.awaited_results.size() != 0) @(posedge clock);
   endtask

   // Write both registers in back-to-back cycles, keeping the enable high between them
   task automatic configure(input logic slave, input logic [7:0] thr);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_SLAVE_MODE;
      csr_wdata <= {7'd0, slave};
      @(posedge clock);
      csr_addr  <= CSR_THRESHOLD;
      csr_wdata <= thr;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_register(CSR_SLAVE_MODE, {7'd0, slave});
      sb.set_register(CSR_THRESHOLD, thr);
   endtask

   task automatic run_directed();
      announce_type top, challenger, probe;
      logic [15:0] probe_hops [8];
      logic [63:0] probe_sender [8];
      logic [15:0] probe_port [8];
      probe_hops   = '{16'd13, 16'd7, 16'd11, 16'd11, 16'd9, 16'd10, 16'd10, 16'd10};
      probe_sender = '{64'd50, 64'd50, 64'd49, 64'd51, 64'd50, 64'd50, 64'd50, 64'd50};
      probe_port   = '{16'd5, 16'd5, 16'd5, 16'd5, 16'd5, 16'd4, 16'd6, 16'd5};

      // first announce is taken as it is; steps removed saturates
      top = '1;
      top.utc_offset = 16'sh8000;
      send_announce(top);
      probe = announce_from(64'd1, 8'd0, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF, '1, 16'hFFFF);
      send_announce(probe);
      send_announce(probe);
      send_announce(top);
      wait_for_results();

      // master mode: time flags stay, UTC fields follow the new master
      configure(1'b0, 8'd1);
      challenger = announce_from(64'd100, 8'h80, 8'h80, 8'h80, 16'h8000, 8'h80,
                                 16'd10, 64'd50, 16'd5);
      challenger.flag_octet = 8'h3F;
      send_announce(challenger);
      wait_for_results();

      // hold the record still and probe each ranking step both ways
      configure(1'b0, 8'd255);
      for (int lvl = 0; lvl < 5; lvl++) begin
         for (int step = -1; step <= 1; step += 2) begin
            probe = refresh_payload(challenger);
            probe.gm_identity = 64'd200;
            case (lvl)
               0: probe.gm_priority1      = 8'(probe.gm_priority1 + step);
               1: probe.gm_clock_class    = 8'(probe.gm_clock_class + step);
               2: probe.gm_clock_accuracy = 8'(probe.gm_clock_accuracy + step);
               3: probe.gm_log_variance   = 16'(probe.gm_log_variance + step);
               default: probe.gm_priority2 = 8'(probe.gm_priority2 + step);
            endcase
            send_announce(probe);
         end
      end
      probe = refresh_payload(challenger);
      probe.gm_identity = 64'd99;
      send_announce(probe);
      probe.gm_identity = 64'd200;
      send_announce(probe);
      for (int i = 0; i < 8; i++) begin
         probe = refresh_payload(challenger);
         probe.hops_removed    = probe_hops[i];
         probe.sender_identity = probe_sender[i];
         probe.sender_port     = probe_port[i];
         send_announce(probe);
      end
   endtask

   // Runs of a better candidate around a threshold of at most 8, near misses and noise
   task automatic run_random(input int count);
      announce_type c;
      int sent, reps, pick, thr_eff;
      sent = 0;
      while (sent < count) begin
         pick    = $urandom_range(0, 99);
         thr_eff = (sb.threshold == 0) ? 1 : sb.threshold;
         if (pick < 50 && thr_eff <= 8) begin
            c    = find_challenger();
            reps = thr_eff + $urandom_range(0, 2) - 1;
            for (int r = 0; r < reps; r++) send_announce(refresh_payload(c));
            sent += reps;
         end else if (pick < 85) begin
            send_announce(derive_announce());
            sent++;
         end else begin
            send_announce(random_announce());
            sent++;
         end
      end
   endtask

   initial begin
      announce_type c;
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      wait_for_results();
      configure(1'b1, 8'd3);
      hold_off_req = 1'b1;
      run_random(40);

      wait_for_results();
      configure(1'b0, 8'd0);
      run_random(30);

      // full-length run up to the largest threshold, then one tie
      wait_for_results();
      configure(1'b1, 8'd255);
      c = find_challenger();
      repeat (256) send_announce(refresh_payload(c));
      run_random(10);

      wait_for_results();
      configure(1'b0, 8'd1);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      run_random(40);
      req_idle_pct = 22;
      rsp_idle_pct = 22;

      wait_for_results();
      configure(1'b1, 8'd2);
      run_random(10);
      wait_for_results();
      run_random(10);

      wait_for_results();
      repeat (4) @(posedge clock);
      if (sb.errors == 0 && sb.awaited_results.size() == 0) begin
         $display("PASS ptp_best_master_select");
      end else begin
         $display("FAIL ptp_best_master_select");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+hdl
hdl/ptpbms_pkg.sv
hdl/ptpbms_rank.sv
hdl/ptpbms_dataset.sv
hdl/ptp_best_master_select.sv
hdl/ptpbms_checker.sv
bench/tb_top.sv
